// ----- design/isq_pkg.sv -----
// ----------------------------------------------------------------------------
// isq_pkg: shared types and constants for the square root simplifier
// Widths, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package isq_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int ROOT_WIDTH      = 17;
	localparam int RAD_WIDTH       = 31;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_WAIT,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic step;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic mag_zero;
		logic div_done;
		logic inner;
		logic quo_lt_cand;
	} status_t;

endpackage

// ----- design/isq_div.sv -----
// ----------------------------------------------------------------------------
// isq_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; quotient and remainder
// hold after the done pulse until the next start.
// ----------------------------------------------------------------------------
module isq_div #(
	parameter int VALUE_WIDTH = isq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quo,
	output logic [VALUE_WIDTH-1:0] rem
);

	localparam int CntWidth = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [CntWidth-1:0]    cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [VALUE_WIDTH+1:0] trial;

	assign trial = {1'b0, rem_q, quo_q[VALUE_WIDTH-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CntWidth'(VALUE_WIDTH);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntWidth'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[VALUE_WIDTH+1]) begin
				rem_q <= trial[VALUE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[VALUE_WIDTH-2:0], quo_q[VALUE_WIDTH-1]};
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- design/isq_datapath.sv -----
// ----------------------------------------------------------------------------
// isq_datapath: trial division datapath
// Holds the remaining magnitude, the candidate divisor and the running root
// factor and radicand; drives the result ports.
// ----------------------------------------------------------------------------
module isq_datapath #(
	parameter int VALUE_WIDTH = isq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [VALUE_WIDTH-1:0]         value,
	input  isq_pkg::cmd_t                         cmd,
	output isq_pkg::status_t                      status,
	output logic                                  done,
	output logic signed [isq_pkg::ROOT_WIDTH-1:0] root_factor,
	output logic [isq_pkg::RAD_WIDTH-1:0]         radicand
);

	localparam int ExtWidth = VALUE_WIDTH + isq_pkg::RAD_WIDTH;

	logic [VALUE_WIDTH-1:0]        m_q;
	logic [VALUE_WIDTH-1:0]        p_q;
	logic [isq_pkg::ROOT_WIDTH-1:0] k_q;
	logic [isq_pkg::RAD_WIDTH-1:0] d_q;
	logic                          neg_q;
	logic                          zero_q;
	logic                          inner_q;
	logic                          odd_q;
	logic                          done_q;
	logic [VALUE_WIDTH-1:0]        mag;
	logic [VALUE_WIDTH-1:0]        quo;
	logic [VALUE_WIDTH-1:0]        rem;
	logic                          div_done;
	logic [ExtWidth-1:0]           p_ext;
	logic [ExtWidth-1:0]           m_ext;

	isq_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(m_q),
		.divisor (p_q),
		.done    (div_done),
		.quo     (quo),
		.rem     (rem)
	);

	assign mag   = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
	assign p_ext = ExtWidth'(p_q);
	assign m_ext = ExtWidth'(m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= 1'b0;
			odd_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load) begin
				inner_q <= 1'b0;
				odd_q   <= 1'b0;
			end else if (cmd.step) begin
				if (rem == '0) begin
					inner_q <= 1'b1;
					odd_q   <= ~odd_q;
				end else begin
					inner_q <= 1'b0;
					odd_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= mag;
			p_q    <= VALUE_WIDTH'(2);
			k_q    <= isq_pkg::ROOT_WIDTH'(1);
			d_q    <= isq_pkg::RAD_WIDTH'(1);
			neg_q  <= value[VALUE_WIDTH-1];
			zero_q <= (mag == '0);
		end else if (cmd.step) begin
			if (rem == '0) begin
				m_q <= quo;
				if (inner_q && odd_q) begin
					k_q <= isq_pkg::ROOT_WIDTH'(k_q * p_ext[isq_pkg::ROOT_WIDTH-1:0]);
				end
			end else begin
				if (inner_q && odd_q) begin
					d_q <= isq_pkg::RAD_WIDTH'(d_q * p_ext[isq_pkg::RAD_WIDTH-1:0]);
				end
				p_q <= (p_q == VALUE_WIDTH'(2)) ? VALUE_WIDTH'(3) : p_q + VALUE_WIDTH'(2);
			end
		end else if (cmd.finish) begin
			if (m_q > VALUE_WIDTH'(1)) begin
				d_q <= isq_pkg::RAD_WIDTH'(d_q * m_ext[isq_pkg::RAD_WIDTH-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (zero_q) begin
				root_factor <= isq_pkg::ROOT_WIDTH'(1);
				radicand    <= '0;
			end else begin
				root_factor <= neg_q ? (~k_q + 1'b1) : k_q;
				radicand    <= d_q;
			end
		end
	end

	assign status.mag_zero    = zero_q;
	assign status.div_done    = div_done;
	assign status.inner       = inner_q;
	assign status.quo_lt_cand = (quo < p_q);
	assign done               = done_q;

	a_odd_needs_inner: assert property (@(posedge clk) disable iff (!arst_n)
		odd_q |-> inner_q)
		else $error("odd exponent flag set outside a run of divisions");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_load_cand: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (p_q == VALUE_WIDTH'(2)) && !inner_q)
		else $error("candidate divisor not restarted at two");

	a_step_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> div_done)
		else $error("datapath advanced without a finished division");

endmodule

// ----- design/isq_ctrl.sv -----
// ----------------------------------------------------------------------------
// isq_ctrl: sequencing controller
// Starts each trial division, decides between another division and the
// final result, and issues the result strobe.
// ----------------------------------------------------------------------------
module isq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  isq_pkg::status_t status,
	output isq_pkg::cmd_t    cmd,
	output logic             busy
);

	isq_pkg::state_t state_q;
	isq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			isq_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = isq_pkg::S_DIV;
				end
			end
			isq_pkg::S_DIV: begin
				if (status.mag_zero) begin
					state_d = isq_pkg::S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = isq_pkg::S_WAIT;
				end
			end
			isq_pkg::S_WAIT: begin
				if (status.div_done) begin
					if (!status.inner && status.quo_lt_cand) begin
						state_d = isq_pkg::S_FINISH;
					end else begin
						cmd.step = 1'b1;
						state_d  = isq_pkg::S_DIV;
					end
				end
			end
			isq_pkg::S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = isq_pkg::S_OUT;
			end
			isq_pkg::S_OUT: begin
				cmd.emit = 1'b1;
				state_d  = isq_pkg::S_IDLE;
			end
			default: begin
				state_d = isq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/integer_sqrt_simplifier_unit.sv -----
// One trial division per candidate divisor (two, then the odd numbers) up
//   to the square root of what remains, plus one per prime factor found.
// Throughput: one transaction at a time, set by the shared bit-serial divider.
// Result strobe done is high for one cycle; the receiver cannot stall.
// Reset clears the controller, the divider and datapath flags and the strobe.
// ----------------------------------------------------------------------------
// integer_sqrt_simplifier_unit: square root simplifier top level
// Splits |value| into root_factor^2 * radicand with a square-free radicand.
// ----------------------------------------------------------------------------
module integer_sqrt_simplifier_unit #(
	parameter int VALUE_WIDTH = isq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [VALUE_WIDTH-1:0]         value,
	output logic                                  done,
	output logic signed [isq_pkg::ROOT_WIDTH-1:0] root_factor,
	output logic [isq_pkg::RAD_WIDTH-1:0]         radicand
);

	isq_pkg::cmd_t    cmd;
	isq_pkg::status_t status;

	isq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	isq_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.done       (done),
		.root_factor(root_factor),
		.radicand   (radicand)
	);

endmodule
